// ===== hdl/bmcr_pkg.sv =====
// ============================================================================
// Byte mix challenge/response package
// Shared types, widths and the round rule codes for the mixing pipeline.
// ============================================================================
package bmcr_pkg;

    localparam int unsigned WORD_W              = 64;
    localparam int unsigned BYTE_W              = 8;
    localparam int unsigned NUM_BYTES           = 8;
    localparam int unsigned ROUND_COUNT_DEFAULT = 32;

    // The word viewed as eight bytes, byte zero in bits 7..0.
    typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] t_bytes;

    // One pipeline slot: a valid bit that travels with its word.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
    } t_stage;

    // Update rule of a round, selected by the round index mod 4.
    typedef enum logic [1:0] {
        RULE_SQUARE = 2'd0,
        RULE_SCALE  = 2'd1,
        RULE_MULT   = 2'd2,
        RULE_SUM    = 2'd3
    } t_rule;

endpackage

// ===== hdl/byte_mix_challenge_response_core.sv =====
// ============================================================================
// Byte mix challenge/response core
// Fully pipelined mixer: one challenge word in per cycle, one response out.
// ============================================================================
// Throughput: one word per cycle; busy is never raised, start may be held high.
// Each round is one stage; rounds of the multiply rule add three shift-add stages.
// Reset clears every stage's valid bit, so no strobe leaves for words in flight.
// The receiver cannot stall: each response is on the ports for exactly one cycle.
module byte_mix_challenge_response_core #(
    parameter int unsigned ROUND_COUNT = bmcr_pkg::ROUND_COUNT_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bmcr_pkg::WORD_W-1:0] i_challenge_in,
    output logic                        o_strobe,
    output logic [bmcr_pkg::WORD_W-1:0] o_response_out
);

    // Every round takes one stage. A round whose index is 2 mod 4 takes three
    // more for its chained shift-adds, so the rounds before round r that
    // carry the extra stages number (r + 1) / 4.
    localparam int unsigned NUM_STAGES = ROUND_COUNT + 3 * ((ROUND_COUNT + 1) >> 2);

    bmcr_pkg::t_stage w_stage [0:NUM_STAGES];

    // The pipeline never holds off a new word.
    assign busy = 1'b0;

    assign w_stage[0].valid = start & ~busy;
    assign w_stage[0].data  = i_challenge_in;

    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        localparam int unsigned BASE = r + 3 * ((r + 1) >> 2);

        bmcr_round_stage #(
            .ROUND_IDX (r)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[BASE]),
            .o_stage (w_stage[BASE+1])
        );

        // The multiply rule ends with three shift-adds, each reading the byte 7
        // that the one before it left, so each gets a stage of its own.
        if ((r & 3) == 2) begin : g_shift
            for (genvar s = 0; s < 3; s++) begin : g_step
                bmcr_shift_stage u_shift (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_stage (w_stage[BASE+1+s]),
                    .o_stage (w_stage[BASE+2+s])
                );
            end
        end
    end

    assign o_strobe       = w_stage[NUM_STAGES].valid;
    assign o_response_out = w_stage[NUM_STAGES].data;

    // An accepted word must occupy the first stage in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_stage[1].valid)
        else $error("accepted word did not enter the first stage");

    // The strobe is the valid bit of the stage before the last, registered once more.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_stage[NUM_STAGES-1].valid))
        else $error("response strobe without a word in the stage before");

    // Reset flushes the pipeline: no response in the first cycle after reset.
    assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_strobe)
        else $error("response strobe right after reset");

endmodule

// ===== hdl/bmcr_round_stage.sv =====
// ============================================================================
// Byte mix round stage
// One registered stage with the byte copy and byte-wise update rule of a round.
// ============================================================================
module bmcr_round_stage #(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmcr_pkg::t_stage i_stage,
    output bmcr_pkg::t_stage o_stage
);

    localparam bmcr_pkg::t_rule RULE = bmcr_pkg::t_rule'(2'(ROUND_IDX & 3));
    localparam logic [2:0] COPY_DST  = 3'(((ROUND_IDX >> 3) + 3) & 7);
    localparam logic [2:0] COPY_SRC  = 3'((ROUND_IDX >> 2) & 3);
    localparam logic [2:0] SQ_DST    = 3'((3 - int'(ROUND_IDX >> 3)) & 7);
    localparam logic [2:0] SQ_SRC    = 3'((ROUND_IDX >> 2) & 7);
    localparam logic [7:0] ROUND_TERM = 8'((7 * ROUND_IDX + 4) & 255);

    logic                         r_valid;
    logic [bmcr_pkg::WORD_W-1:0]  r_data;
    bmcr_pkg::t_bytes             n_data;

    always_comb begin
        n_data = bmcr_pkg::t_bytes'(i_stage.data);
        if (RULE != bmcr_pkg::RULE_SQUARE) begin
            n_data[COPY_DST] = n_data[COPY_SRC];
        end
        case (RULE)
            bmcr_pkg::RULE_SQUARE: begin
                n_data[SQ_DST] = n_data[SQ_SRC];
                n_data[5]      = n_data[5] + 8'd3 * n_data[6];
                for (int n = 0; n < 3; n++) begin
                    n_data[3] = n_data[3] * (n_data[3] + 8'd1);
                end
            end
            bmcr_pkg::RULE_SCALE: begin
                n_data[0] = (n_data[0] << 3) + ROUND_TERM;
                n_data[6] = n_data[6] + 8'd3 * n_data[3];
            end
            bmcr_pkg::RULE_MULT: begin
                // The word-wide shift-adds of this rule follow in their own stages.
                for (int n = 0; n < 3; n++) begin
                    n_data[1] = n_data[1] * (n_data[6] + 8'd1);
                end
            end
            bmcr_pkg::RULE_SUM: begin
                n_data[2] = n_data[2] + (n_data[3] << 2) + n_data[4] + n_data[5];
                n_data[4] = n_data[4] + 8'd9 * n_data[2] + 8'd9;
            end
            default: begin
                n_data = bmcr_pkg::t_bytes'(i_stage.data);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= bmcr_pkg::WORD_W'(n_data);
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// ===== hdl/bmcr_shift_stage.sv =====
// ============================================================================
// Byte mix shift-add stage
// One registered stage that adds the word to itself shifted by byte 7's low nibble.
// ============================================================================
module bmcr_shift_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmcr_pkg::t_stage i_stage,
    output bmcr_pkg::t_stage o_stage
);

    logic                        r_valid;
    logic [bmcr_pkg::WORD_W-1:0] r_data;
    logic [bmcr_pkg::WORD_W-1:0] n_data;
    logic [3:0]                  shift_amt;

    assign shift_amt = i_stage.data[59:56];
    assign n_data    = i_stage.data + (i_stage.data << shift_amt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

// ===== bench/byte_mix_challenge_response_core_tb.sv =====
// ============================================================================
// Byte mix challenge/response core testbench
// Drives challenge words through the core under the start/busy handshake,
// predicts every response with a local copy of the round rules, and checks
// each strobed response in order against the oldest prediction.
// ============================================================================
module byte_mix_challenge_response_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bmcr_pkg::*;

    // The core runs at its default round count. Its latency, reckoned from its
    // stage count, sets how long the bench waits for stray strobes.
    localparam int unsigned ROUNDS       = ROUND_COUNT_DEFAULT;
    localparam int unsigned LATENCY      = ROUNDS + 3 * ((ROUNDS + 1) / 4);
    localparam int unsigned RANDOM_WORDS = 800;
    localparam int unsigned MAX_PRINTED  = 20;

    // ------------------------------------------------------------------------
    // Response scoreboard. It turns every accepted challenge word into the
    // response word the core must return and matches strobed responses
    // against those predictions in arrival order.
    // ------------------------------------------------------------------------
    class ResponseScoreboard;
        logic [WORD_W-1:0] expected_responses[$];
        int unsigned       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // All rounds applied to one challenge word; byte k sits in bits
        // 8k+7..8k and all byte arithmetic wraps at 256.
        static function logic [WORD_W-1:0] mix_challenge(logic [WORD_W-1:0] challenge);
            t_bytes            b;
            logic [WORD_W-1:0] w;
            int unsigned       r;
            b = challenge;
            for (r = 0; r < ROUNDS; r++) begin
                // Every round off a multiple of four starts with a byte copy.
                if (r[1:0] != 2'd0) begin
                    b[((r >> 3) + 3) & 7] = b[(r >> 2) & 3];
                end
                case (t_rule'(r[1:0]))
                    RULE_SQUARE: begin
                        b[(3 - (r >> 3)) & 7] = b[(r >> 2) & 7];
                        b[5] = 8'(b[5] + 3 * b[6]);
                        repeat (3) b[3] = 8'(b[3] * (b[3] + 1));
                    end
                    RULE_SCALE: begin
                        b[0] = 8'(b[0] * 8 + 7 * r + 4);
                        b[6] = 8'(b[6] + 3 * b[3]);
                    end
                    RULE_MULT: begin
                        repeat (3) b[1] = 8'(b[1] * (b[6] + 1));
                        // The shift amount is re-read from byte 7 on each pass,
                        // since the previous pass may have changed it.
                        repeat (3) begin
                            w = b;
                            w = w + (w << b[7][3:0]);
                            b = w;
                        end
                    end
                    RULE_SUM: begin
                        b[2] = 8'(b[2] + 4 * b[3] + b[4] + b[5]);
                        b[4] = 8'(b[4] + 9 * b[2] + 9);
                    end
                endcase
            end
            return b;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED) begin
                $display("%0t ns: mismatch: %s", $time, what);
            end
        endtask

        function void note_challenge(logic [WORD_W-1:0] challenge);
            expected_responses.push_back(mix_challenge(challenge));
        endfunction

        task check_response(logic [WORD_W-1:0] response);
            logic [WORD_W-1:0] want;
            if (expected_responses.size() == 0) begin
                report_mismatch($sformatf("response %h with no challenge pending", response));
            end else begin
                want = expected_responses.pop_front();
                if (response !== want) begin
                    report_mismatch($sformatf("response_out %h, expected %h", response, want));
                end
            end
        endtask

        function int unsigned outstanding();
            return expected_responses.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input holds a known value
    // from time zero.
    // ------------------------------------------------------------------------
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic [WORD_W-1:0] i_challenge_in = '0;
    logic              busy;
    logic              o_strobe;
    logic [WORD_W-1:0] o_response_out;

    ResponseScoreboard scoreboard;
    int unsigned       burst_left = 0;

    always #5 i_clk = ~i_clk;

    byte_mix_challenge_response_core #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_challenge_in(i_challenge_in),
        .o_strobe      (o_strobe),
        .o_response_out(o_response_out)
    );

    // ------------------------------------------------------------------------
    // Monitor. Inputs change only by nonblocking assignment at the rising
    // edge, so the values read here are the ones the core saw at that edge.
    // A word is taken when start is high and busy is low; a response counts
    // at the edge that closes its strobe cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                scoreboard.note_challenge(i_challenge_in);
            end
            if ($isunknown(o_strobe)) begin
                scoreboard.report_mismatch("strobe is unknown");
            end else if (o_strobe) begin
                scoreboard.check_response(o_response_out);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one challenge word and returns at the edge that takes it. Start
    // stays high on return, so back-to-back words need no extra assignment.
    task send_word(logic [WORD_W-1:0] challenge);
        start          <= 1'b1;
        i_challenge_in <= challenge;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drops start for a number of cycles while the data lines carry junk,
    // which the core must ignore.
    task idle_cycles(int unsigned cycles);
        if (cycles != 0) begin
            start <= 1'b0;
            repeat (cycles) begin
                i_challenge_in <= {$urandom, $urandom};
                @(posedge i_clk);
            end
        end
    endtask

    // Gap length between words: mostly none or short, now and then long, and
    // occasional bursts with no gap at all so the pipeline runs full.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            burst_left = $urandom_range(10, 80);
            return 0;
        end else if (roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 30);
        end
        return $urandom_range(31, 150);
    endfunction

    // Holds the sender back until every expected response has come out. The
    // first edge lets the monitor log the word taken at the edge just passed.
    task wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (scoreboard.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random challenge words: fully random ones mostly, plus words built from
    // the byte extremes and words with a single live byte, which stress the
    // byte copies and the shift amount taken from byte 7.
    function automatic logic [WORD_W-1:0] random_challenge();
        t_bytes b;
        int     k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: b = {$urandom, $urandom};
            6: begin
                for (k = 0; k < NUM_BYTES; k++) begin
                    case ($urandom_range(0, 2))
                        0:       b[k] = 8'h00;
                        1:       b[k] = 8'hFF;
                        default: b[k] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
            7: begin
                b = ($urandom_range(0, 1) != 0) ? '1 : '0;
                b[$urandom_range(0, NUM_BYTES - 1)] = 8'($urandom_range(0, 255));
            end
            8: b = {$urandom, $urandom} & {$urandom, $urandom};
            default: b = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        return b;
    endfunction

    // Directed words: all zeros and all ones, single bits at both ends,
    // alternating patterns, each byte alone at its maximum, and byte 7 set so
    // that the shift-add rule sees shift amounts of zero and fifteen.
    logic [WORD_W-1:0] directed_words[$] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FF00,
        64'h0000_0000_00FF_0000, 64'h0000_0000_FF00_0000,
        64'h0000_00FF_0000_0000, 64'h0000_FF00_0000_0000,
        64'h00FF_0000_0000_0000, 64'hFF00_0000_0000_0000,
        64'h0F00_0000_0000_0000, 64'hF0FF_FFFF_FFFF_FFFF,
        64'h0FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, 64'h7F80_7F80_7F80_7F80
    };

    initial begin
        int unsigned n;
        scoreboard = new();

        // Reset is held from time zero and then released for good.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i]);
            idle_cycles(($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0);
        end
        wait_for_drain();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            send_word(random_challenge());
            // A full drain now and then lets the pipeline empty completely
            // with the sender holding off.
            if (n % 250 == 249) begin
                wait_for_drain();
            end else begin
                idle_cycles(pick_gap());
            end
        end

        // Let the last responses out, then watch a little longer so that a
        // strobe with nothing behind it is still caught.
        wait_for_drain();
        repeat (LATENCY + 10) @(posedge i_clk);

        if (scoreboard.outstanding() != 0) begin
            scoreboard.report_mismatch($sformatf("%0d responses never came",
                                                 scoreboard.outstanding()));
        end
        if (scoreboard.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run, which stays under two
    // milliseconds of simulated time even with every gap at its longest.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
